### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Standalone header; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/psu_pkg.sv
// Shared constants, types and the Paeth predictor for the scanline unfilter.
// No dependencies.
package psu_pkg;

  localparam int MaxWidth   = 4096;
  localparam int IdxW       = $clog2(MaxWidth);
  localparam int ColW       = 13;
  localparam int RowW       = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int QueueDepth = 4;
  localparam int OutDepth   = 2;

  localparam logic [CfgIdxW-1:0] REG_ROW_WIDTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [7:0] FILT_NONE  = 8'h00;
  localparam logic [7:0] FILT_SUB   = 8'h01;
  localparam logic [7:0] FILT_UP    = 8'h02;
  localparam logic [7:0] FILT_AVG   = 8'h03;
  localparam logic [7:0] FILT_PAETH = 8'h04;

  // One classified pixel, front to back.
  typedef struct packed {
    logic [7:0]      data;
    logic [IdxW-1:0] idx;
    logic            col_first;
    logic            first_row;
    logic            row_end;
    logic            img_end;
    logic [7:0]      filt;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_last;
    logic       image_last;
    logic       filter_unknown;
  } res_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] sa, sb, sc, da, db, dc;
    logic [9:0] pa, pb, pc;
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    sc = signed'({2'b00, c});
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

endpackage

### rtl/core/psu_ram.sv
// Generic simple dual-port RAM, registered read (old data on collision).
// No dependencies.
module psu_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/psu_queue.sv
// Short command queue between the front and back parts.
// Depends on psu_pkg.
module psu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psu_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output psu_pkg::cmd_t cmd_o
);
  import psu_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= cmd_i;
  end

endmodule

### rtl/core/psu_front.sv
// Front part: config registers, row/column tracking, byte classification.
// Depends on psu_pkg.
module psu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [psu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          push_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          full_o,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output psu_pkg::cmd_t                 q_cmd_o
);
  import psu_pkg::*;

  logic [ColW-1:0] row_width_q, row_width_d;
  logic [RowW-1:0] image_height_q, image_height_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [7:0]      filt_q, filt_d;
  logic [ColW-1:0] width_eff, col_m1;
  logic [RowW-1:0] height_eff;
  logic            accept, row_end, img_end;

  // Zero acts as one; oversize clamps to the line buffer depth.
  always_comb begin
    if (row_width_q == '0) width_eff = ColW'(1);
    else if (row_width_q > ColW'(MaxWidth)) width_eff = ColW'(MaxWidth);
    else width_eff = row_width_q;
    height_eff = (image_height_q == '0) ? RowW'(1) : image_height_q;
  end

  assign full_o  = q_full_i;
  assign accept  = push_i && !q_full_i;
  assign col_m1  = col_q - ColW'(1);
  assign row_end = (col_q >= width_eff);
  assign img_end = row_end && (({1'b0, row_q} + (RowW + 1)'(1)) >= {1'b0, height_eff});

  assign q_push_o          = accept && (col_q != '0);
  assign q_cmd_o.data      = data_byte_i;
  assign q_cmd_o.idx       = col_m1[IdxW-1:0];
  assign q_cmd_o.col_first = (col_q == ColW'(1));
  assign q_cmd_o.first_row = (row_q == '0);
  assign q_cmd_o.row_end   = row_end;
  assign q_cmd_o.img_end   = img_end;
  assign q_cmd_o.filt      = filt_q;

  always_comb begin
    row_width_d    = row_width_q;
    image_height_d = image_height_q;
    col_d          = col_q;
    row_d          = row_q;
    filt_d         = filt_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_WIDTH:    row_width_d    = cfg_data_i[ColW-1:0];
        REG_IMAGE_HEIGHT: image_height_d = cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
    if (accept) begin
      if (col_q == '0) begin
        filt_d = data_byte_i;
        col_d  = ColW'(1);
      end else if (row_end) begin
        col_d = '0;
        row_d = img_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= ColW'(1);
      image_height_q <= RowW'(1);
      col_q          <= '0;
      row_q          <= '0;
      filt_q         <= '0;
    end else begin
      row_width_q    <= row_width_d;
      image_height_q <= image_height_d;
      col_q          <= col_d;
      row_q          <= row_d;
      filt_q         <= filt_d;
    end
  end

endmodule

### rtl/core/psu_back.sv
// Back part: line buffer read, pixel reconstruction, result buffer.
// Depends on psu_pkg and psu_ram.
module psu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  psu_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output psu_pkg::res_t res_o
);
  import psu_pkg::*;

  localparam int OutPtrW = $clog2(OutDepth);
  localparam int OutCntW = $clog2(OutDepth + 1);

  logic             b_valid_q, b_valid_d;
  cmd_t             b_cmd_q;
  logic             fwd_hit_q;
  logic [7:0]       fwd_data_q;
  logic [7:0]       left_q, ul_q;
  logic [7:0]       ram_rdata;
  logic [7:0]       a, up, c, r, avg;
  logic             fire, issue;
  res_t             ob_q [OutDepth];
  logic [OutPtrW-1:0] ob_wr_q, ob_rd_q;
  logic [OutCntW-1:0] ob_cnt_q;
  logic             ob_pop;
  logic [8:0]       ab_sum;

  assign fire    = b_valid_q && (ob_cnt_q != OutCntW'(OutDepth));
  assign issue   = q_valid_i && (!b_valid_q || fire);
  assign q_pop_o = issue;
  assign b_valid_d = issue ? 1'b1 : (fire ? 1'b0 : b_valid_q);

  psu_ram #(
    .Width(8),
    .Depth(MaxWidth)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (fire),
    .waddr_i(b_cmd_q.idx),
    .wdata_i(r),
    .re_i   (issue),
    .raddr_i(q_cmd_i.idx),
    .rdata_o(ram_rdata)
  );

  // Neighbors; the RAM returns old data when written in the read cycle.
  always_comb begin
    a  = b_cmd_q.col_first ? 8'h00 : left_q;
    up = b_cmd_q.first_row ? 8'h00 : (fwd_hit_q ? fwd_data_q : ram_rdata);
    c  = (b_cmd_q.col_first || b_cmd_q.first_row) ? 8'h00 : ul_q;
    ab_sum = {1'b0, a} + {1'b0, up};
    avg = ab_sum[8:1];
    case (b_cmd_q.filt)
      FILT_NONE:  r = b_cmd_q.data;
      FILT_SUB:   r = b_cmd_q.data + a;
      FILT_UP:    r = b_cmd_q.data + up;
      FILT_AVG:   r = b_cmd_q.data + avg;
      FILT_PAETH: r = b_cmd_q.data + paeth(a, up, c);
      default:    r = b_cmd_q.data;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      left_q    <= '0;
      ul_q      <= '0;
    end else begin
      b_valid_q <= b_valid_d;
      if (fire) begin
        left_q <= r;
        ul_q   <= up;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_cmd_q    <= q_cmd_i;
      fwd_hit_q  <= fire && (b_cmd_q.idx == q_cmd_i.idx);
      fwd_data_q <= r;
    end
  end

  // Two-entry result buffer.
  assign empty_o = (ob_cnt_q == '0);
  assign ob_pop  = pop_i && !empty_o;
  assign res_o   = ob_q[ob_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= '0;
      ob_rd_q  <= '0;
      ob_cnt_q <= '0;
    end else begin
      if (fire)
        ob_wr_q <= (ob_wr_q == OutPtrW'(OutDepth - 1)) ? '0 : ob_wr_q + OutPtrW'(1);
      if (ob_pop)
        ob_rd_q <= (ob_rd_q == OutPtrW'(OutDepth - 1)) ? '0 : ob_rd_q + OutPtrW'(1);
      if (fire && !ob_pop) ob_cnt_q <= ob_cnt_q + OutCntW'(1);
      else if (!fire && ob_pop) ob_cnt_q <= ob_cnt_q - OutCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ob_q[ob_wr_q].pixel          <= r;
      ob_q[ob_wr_q].row_last       <= b_cmd_q.row_end;
      ob_q[ob_wr_q].image_last     <= b_cmd_q.img_end;
      ob_q[ob_wr_q].filter_unknown <= (b_cmd_q.filt > FILT_PAETH);
    end
  end

endmodule

### rtl/core/png_scanline_unfilter.sv
// PNG scanline unfilter: front classifier, command queue, reconstruction back end.
// Depends on psu_pkg, psu_front, psu_queue, psu_back, psu_ram.
//
// Usage:
//   Input queue side: push a byte of the inflated stream with push; it is taken
//   when full is low. The first byte of each row is its filter type and gives
//   no result; each further byte yields one reconstructed pixel.
//   Result queue side: while empty is low the oldest pixel and its row_last,
//   image_last and filter_unknown marks are shown; pop takes it.
//   Config: cfg_we_i with cfg_index_i 0 sets row_width, 1 sets image_height;
//   other indexes are ignored. Write only while the block is idle.
// Path: a byte goes through the command queue, back-end stage and result buffer.
// Throughput: one byte per cycle sustained while pop keeps up; Sub/Average/Paeth
//   left-pixel loop closes through register left_q in the back end, and the line
//   buffer has one read and one write port, bypassed for a write to the read entry.
// Stall: when pop stays low the result buffer (2 entries) and then the
//   4-entry command queue fill, and full rises; nothing is dropped.
// Reset: queues empty, position at the filter byte of the first row,
//   row_width = 1, image_height = 1. The line buffer is not cleared; the first
//   row of each image ignores what it reads.
module png_scanline_unfilter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [psu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    pixel_o,
  output logic                          row_last_o,
  output logic                          image_last_o,
  output logic                          filter_unknown_o
);
  import psu_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t front_cmd, queue_cmd;
  res_t res;

  psu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .data_byte_i(data_byte_i),
    .full_o     (full),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (front_cmd)
  );

  psu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (queue_cmd)
  );

  psu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_cmd_i  (queue_cmd),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .res_o    (res)
  );

  assign pixel_o          = res.pixel;
  assign row_last_o       = res.row_last;
  assign image_last_o     = res.image_last;
  assign filter_unknown_o = res.filter_unknown;

endmodule

### rtl/core/psu_checker.sv
// Port-level checker for png_scanline_unfilter, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module psu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] pixel_o,
  input logic       row_last_o,
  input logic       image_last_o,
  input logic       filter_unknown_o
);

  // Input backs up only while a result is waiting.
  `ASSERT_IMPLY(a_full_needs_results, clk_i, rst_ni, full, !empty)

  // The last pixel of an image also ends its row.
  `ASSERT_IMPLY(a_image_end_is_row_end, clk_i, rst_ni, !empty && image_last_o, row_last_o)

  // A waiting result holds until taken.
  `ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(pixel_o) && $stable(row_last_o) && $stable(image_last_o) && $stable(filter_unknown_o))

endmodule

bind png_scanline_unfilter psu_checker u_checker (.*);
